FILE: rtl/stbs_pkg.sv
package stbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int COUNT_W = IDX_W + 1;
   localparam int WORD_W = 32;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic write_entry;
      logic load_search;
      logic probe;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic range_empty;
      logic hit;
      logic slot_free;
   } status_type;

endpackage

FILE: rtl/stbs_if.sv
interface stbs_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic [stbs_pkg::IDX_W-1:0]         write_index;
   logic signed [stbs_pkg::WORD_W-1:0] entry_value;
   logic signed [stbs_pkg::WORD_W-1:0] search_key;

   modport source (output valid, func, write_index, entry_value, search_key, input ready);
   modport sink (input valid, func, write_index, entry_value, search_key, output ready);
endinterface

interface stbs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [stbs_pkg::IDX_W-1:0] match_index;

   modport source (output valid, found, match_index, input ready);
   modport sink (input valid, found, match_index, output ready);
endinterface

FILE: rtl/stbs_datapath.sv
module stbs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  stbs_pkg::cmd_type                  cmd,
   output stbs_pkg::status_type               status,
   input  logic                               csr_we,
   input  logic [stbs_pkg::COUNT_W-1:0]       csr_wdata,
   input  logic [stbs_pkg::IDX_W-1:0]         write_index,
   input  logic signed [stbs_pkg::WORD_W-1:0] entry_value,
   input  logic signed [stbs_pkg::WORD_W-1:0] search_key,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [stbs_pkg::IDX_W-1:0]         rsp_match_index
);

   logic signed [stbs_pkg::WORD_W-1:0] table_mem [stbs_pkg::TABLE_DEPTH];

   logic [stbs_pkg::COUNT_W-1:0]       count_ff;
   logic [stbs_pkg::COUNT_W-1:0]       count_sat;
   logic [stbs_pkg::COUNT_W-1:0]       lo_ff;
   logic [stbs_pkg::COUNT_W-1:0]       lo_in;
   logic [stbs_pkg::COUNT_W-1:0]       hi_ff;
   logic [stbs_pkg::COUNT_W-1:0]       hi_in;
   logic signed [stbs_pkg::WORD_W-1:0] key_ff;
   logic [stbs_pkg::IDX_W-1:0]         mid_ff;
   logic [stbs_pkg::IDX_W-1:0]         mid_in;
   logic [stbs_pkg::COUNT_W:0]         mid_sum;
   logic signed [stbs_pkg::WORD_W-1:0] rdata_ff;
   logic                               found_ff;
   logic                               found_in;
   logic [stbs_pkg::IDX_W-1:0]         where_ff;
   logic [stbs_pkg::IDX_W-1:0]         where_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               rsp_found_ff;
   logic [stbs_pkg::IDX_W-1:0]         rsp_index_ff;
   logic                               less;

   // The table is loaded through writes; entries never written hold no defined value.
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         table_mem[write_index] <= entry_value;
      end
      if (cmd.probe) begin
         rdata_ff <= table_mem[mid_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (count_ff > stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH)) begin
         count_sat = stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH);
      end else begin
         count_sat = count_ff;
      end
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (stbs_pkg::COUNT_W+1)'(1);
   assign mid_in = mid_sum[stbs_pkg::IDX_W:1];
   assign less = rdata_ff < key_ff;

   assign status.range_empty = lo_ff >= hi_ff;
   assign status.hit = rdata_ff == key_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      found_in = found_ff;
      where_in = where_ff;
      if (cmd.load_search) begin
         lo_in = '0;
         hi_in = count_sat;
         found_in = 1'b0;
         where_in = '0;
      end else if (cmd.update) begin
         if (status.hit) begin
            found_in = 1'b1;
            where_in = mid_ff;
         end else if (less) begin
            lo_in = stbs_pkg::COUNT_W'(mid_ff) + stbs_pkg::COUNT_W'(1);
         end else begin
            hi_in = stbs_pkg::COUNT_W'(mid_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      found_ff <= found_in;
      where_ff <= where_in;
      if (cmd.load_search) begin
         key_ff <= search_key;
      end
      if (cmd.probe) begin
         mid_ff <= mid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= where_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;

endmodule

FILE: rtl/stbs_ctrl.sv
module stbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_ready,
   input  stbs_pkg::status_type status,
   output stbs_pkg::cmd_type    cmd
);

   stbs_pkg::state_type state_ff;
   stbs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (req_valid && req_func == stbs_pkg::FUNC_SEARCH) begin
               state_in = stbs_pkg::ST_READ;
            end
         end
         stbs_pkg::ST_READ: begin
            if (status.range_empty) begin
               state_in = stbs_pkg::ST_DONE;
            end else begin
               state_in = stbs_pkg::ST_CMP;
            end
         end
         stbs_pkg::ST_CMP: begin
            if (status.hit) begin
               state_in = stbs_pkg::ST_DONE;
            end else begin
               state_in = stbs_pkg::ST_READ;
            end
         end
         stbs_pkg::ST_DONE: begin
            if (status.slot_free) begin
               state_in = stbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         stbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.write_entry = req_valid && req_func == stbs_pkg::FUNC_WRITE;
            cmd.load_search = req_valid && req_func == stbs_pkg::FUNC_SEARCH;
         end
         stbs_pkg::ST_READ: begin
            cmd.probe = !status.range_empty;
         end
         stbs_pkg::ST_CMP: begin
            cmd.update = 1'b1;
         end
         stbs_pkg::ST_DONE: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/sorted_table_binary_search_top.sv
// Sorted table with binary search over 1024 signed 32-bit entries. A write transaction
// stores one entry and returns no response. A search transaction probes midpoints
// of entries 0 to csr_wdata-1 (saturated at 1024) and returns found and the matching
// index, or not found with index 0. Each probe has two steps, the registered table
// read and then the signed compare, and a search makes at most eleven probes on a
// full table. Requests are taken while the block is idle, also when an earlier
// response still waits in the output register. Entries must be loaded in ascending
// order, and a search must not reach an entry that was never written.
module sorted_table_binary_search_top (
   input  logic                         clock,
   input  logic                         reset,
   stbs_req_if.sink                     req_if,
   stbs_rsp_if.source                   rsp_if,
   input  logic                         csr_we,
   input  logic [stbs_pkg::COUNT_W-1:0] csr_wdata
);

   stbs_pkg::cmd_type    cmd;
   stbs_pkg::status_type status;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .write_index     (req_if.write_index),
      .entry_value     (req_if.entry_value),
      .search_key      (req_if.search_key),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_found       (rsp_if.found),
      .rsp_match_index (rsp_if.match_index)
   );

`ifndef NO_ASSERTIONS
   // A new response is never loaded over one that has not been taken.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.slot_free)
      else $error("response register overwritten");

   // A miss always reports index zero.
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.found |-> rsp_if.match_index == '0)
      else $error("miss with nonzero index");

   // A search transaction blocks the request channel in the following cycle.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.func == stbs_pkg::FUNC_SEARCH |=> !req_if.ready)
      else $error("request taken during search");

   // The table is read only while the search range is not empty.
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      cmd.probe |-> !status.range_empty)
      else $error("probe of empty range");
`endif

endmodule
